// ===== rtl/dqar_pkg.sv =====
// ----------------------------------------------------------------------------
// dqar_pkg
// Shared types, constants and sizes for the DNS query answer rewriter.
// ----------------------------------------------------------------------------
package dqar_pkg;

  // largest datagram taken in, bytes past it are ignored
  localparam int MAX_PACKET = 512;

  // byte offset counter, able to hold MAX_PACKET itself
  localparam int IDX_W   = $clog2(MAX_PACKET) + 1;
  // label pointer, one length byte past the last offset plus a full label
  localparam int LABEL_W = $clog2(MAX_PACKET + 256);

  // answer record appended to every reply
  localparam int TAIL_LEN = 16;
  localparam int TAIL_W   = $clog2(TAIL_LEN);

  // queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // header layout
  localparam int          HDR_LEN      = 12;
  localparam logic [3:0]  OFF_ID_HI    = 4'd0;
  localparam logic [3:0]  OFF_ID_LO    = 4'd1;
  localparam logic [3:0]  OFF_FLAGS_HI = 4'd2;
  localparam logic [3:0]  OFF_FLAGS_LO = 4'd3;
  localparam logic [3:0]  OFF_QD_HI    = 4'd4;
  localparam logic [3:0]  OFF_QD_LO    = 4'd5;
  localparam logic [3:0]  OFF_AN_LO    = 4'd7;
  localparam int          QR_BIT       = 7;
  localparam logic [7:0]  FLAGS_HI     = 8'h81;
  localparam logic [7:0]  FLAGS_LO     = 8'h80;
  localparam logic [7:0]  ANCOUNT_LO   = 8'h01;

  // QTYPE and QCLASS follow the zero label
  localparam int QTAIL_LEN = 5;

  // fixed parts of the answer record
  localparam logic [15:0] NAME_PTR   = 16'hC00C;
  localparam logic [15:0] TYPE_A     = 16'h0001;
  localparam logic [15:0] CLASS_IN   = 16'h0001;
  localparam logic [15:0] RDLEN_IPV4 = 16'h0004;

  // configuration register indexes
  localparam int         CFG_IDX_W          = 1;
  localparam logic [0:0] CFG_ANSWER_ADDRESS = 1'd0;
  localparam logic [0:0] CFG_ANSWER_TTL     = 1'd1;
  localparam logic [31:0] ADDRESS_RESET     = 32'hC0A80401;
  localparam logic [31:0] TTL_RESET         = 32'd60;

  // verdict codes on the result stream
  localparam logic [1:0] VERDICT_BYTE    = 2'd0;
  localparam logic [1:0] VERDICT_SEND    = 2'd1;
  localparam logic [1:0] VERDICT_DISCARD = 2'd2;

  typedef enum logic [1:0] {
    PH_NAME,
    PH_QTYPE,
    PH_DROP
  } phase_t;

  // one request from front to back
  typedef struct packed {
    logic [7:0] data;  // reply byte, valid when emit
    logic       emit;  // data carries a reply byte
    logic       fin;   // end of datagram
    logic       ok;    // datagram answered, append record
  } q_entry_t;

endpackage

// ===== rtl/dqar_front.sv =====
// ----------------------------------------------------------------------------
// dqar_front
// Walks the header and QNAME of each query and classifies every byte.
// ----------------------------------------------------------------------------
module dqar_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               push,
  output dqar_pkg::q_entry_t push_entry
);

  localparam logic [dqar_pkg::IDX_W-1:0] PKT_LIMIT =
    dqar_pkg::IDX_W'(dqar_pkg::MAX_PACKET);
  localparam logic [dqar_pkg::IDX_W-1:0] HDR_END =
    dqar_pkg::IDX_W'(dqar_pkg::HDR_LEN);
  localparam logic [dqar_pkg::LABEL_W-1:0] QE_LIMIT =
    dqar_pkg::LABEL_W'(dqar_pkg::MAX_PACKET - dqar_pkg::TAIL_LEN);
  localparam logic [dqar_pkg::LABEL_W-1:0] FIRST_LABEL =
    dqar_pkg::LABEL_W'(dqar_pkg::HDR_LEN);

  logic [dqar_pkg::IDX_W-1:0]   byte_index, byte_index_next;
  logic [dqar_pkg::LABEL_W-1:0] next_label_at, next_label_at_next;
  logic [dqar_pkg::IDX_W-1:0]   question_end, question_end_next;
  dqar_pkg::phase_t             phase, phase_next;
  logic                         reject, reject_next;

  logic                         emit;
  logic [7:0]                   ob;
  logic                         answer_ok;
  logic [dqar_pkg::LABEL_W-1:0] qe_wide;
  logic [dqar_pkg::IDX_W-1:0]   idx_plus1;

  // per-datagram walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      next_label_at <= FIRST_LABEL;
      question_end  <= '0;
      phase         <= dqar_pkg::PH_NAME;
      reject        <= 1'b0;
    end else if (in_fire) begin
      byte_index    <= byte_index_next;
      next_label_at <= next_label_at_next;
      question_end  <= question_end_next;
      phase         <= phase_next;
      reject        <= reject_next;
    end
  end

  // classify the current byte
  always_comb begin
    emit               = 1'b0;
    ob                 = '0;
    reject_next        = reject;
    phase_next         = phase;
    next_label_at_next = next_label_at;
    question_end_next  = question_end;
    byte_index_next    = byte_index;
    idx_plus1          = byte_index + 1'b1;
    qe_wide            = dqar_pkg::LABEL_W'(byte_index) +
                         dqar_pkg::LABEL_W'(dqar_pkg::QTAIL_LEN);

    if (byte_index < PKT_LIMIT) begin
      byte_index_next = idx_plus1;
      if (!reject) begin
        if (byte_index < HDR_END) begin
          // fixed header rewrite
          emit = 1'b1;
          case (byte_index[3:0])
            dqar_pkg::OFF_FLAGS_HI: begin
              ob = dqar_pkg::FLAGS_HI;
              if (in_byte[dqar_pkg::QR_BIT]) reject_next = 1'b1;
            end
            dqar_pkg::OFF_FLAGS_LO: ob = dqar_pkg::FLAGS_LO;
            dqar_pkg::OFF_AN_LO:    ob = dqar_pkg::ANCOUNT_LO;
            dqar_pkg::OFF_ID_HI,
            dqar_pkg::OFF_ID_LO,
            dqar_pkg::OFF_QD_HI,
            dqar_pkg::OFF_QD_LO:    ob = in_byte;
            default:                ob = '0;
          endcase
        end else if (phase == dqar_pkg::PH_NAME) begin
          // label walk through QNAME
          emit = 1'b1;
          ob   = in_byte;
          if (dqar_pkg::LABEL_W'(byte_index) == next_label_at) begin
            if (in_byte == 8'd0) begin
              question_end_next = qe_wide[dqar_pkg::IDX_W-1:0];
              if (qe_wide > QE_LIMIT) reject_next = 1'b1;
              else phase_next = dqar_pkg::PH_QTYPE;
            end else begin
              next_label_at_next = dqar_pkg::LABEL_W'(byte_index) +
                                   dqar_pkg::LABEL_W'(in_byte) + 1'b1;
            end
          end
        end else if (phase == dqar_pkg::PH_QTYPE) begin
          // QTYPE and QCLASS copied
          if (byte_index < question_end) begin
            emit = 1'b1;
            ob   = in_byte;
          end
          if (idx_plus1 >= question_end) phase_next = dqar_pkg::PH_DROP;
        end
      end
    end

    answer_ok = !reject_next && (phase_next == dqar_pkg::PH_DROP);

    // hand the byte over
    push            = in_fire && (in_last || (emit && !reject_next));
    push_entry.fin  = in_last;
    push_entry.ok   = answer_ok;
    push_entry.emit = emit && !reject_next && (!in_last || answer_ok);
    push_entry.data = ob;

    // end of datagram restarts the walk
    if (in_last) begin
      byte_index_next    = '0;
      next_label_at_next = FIRST_LABEL;
      question_end_next  = '0;
      phase_next         = dqar_pkg::PH_NAME;
      reject_next        = 1'b0;
    end
  end

endmodule

// ===== rtl/dqar_queue.sv =====
// ----------------------------------------------------------------------------
// dqar_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module dqar_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dqar_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output dqar_pkg::q_entry_t head
);

  dqar_pkg::q_entry_t                mem [dqar_pkg::QDEPTH];
  logic [dqar_pkg::QPTR_W-1:0]       wr_ptr;
  logic [dqar_pkg::QPTR_W-1:0]       rd_ptr;
  logic [dqar_pkg::QCNT_W-1:0]       count;

  assign full       = (count == dqar_pkg::QCNT_W'(dqar_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/dqar_back.sv =====
// ----------------------------------------------------------------------------
// dqar_back
// Expands queued requests into reply bytes and appends the answer record.
// ----------------------------------------------------------------------------
module dqar_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  dqar_pkg::q_entry_t head,
  output logic               pop,
  input  logic [31:0]        answer_address,
  input  logic [31:0]        answer_ttl,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic [1:0]         verdict
);

  localparam logic [dqar_pkg::TAIL_W-1:0] TAIL_FINAL =
    dqar_pkg::TAIL_W'(dqar_pkg::TAIL_LEN - 1);

  logic                        tail_on, tail_on_next;
  logic [dqar_pkg::TAIL_W-1:0] tail_idx, tail_idx_next;
  logic                        load;
  logic [7:0]                  byte_next;
  logic                        last_next;
  logic [1:0]                  verdict_next;
  logic [8*dqar_pkg::TAIL_LEN-1:0] record;
  logic [dqar_pkg::TAIL_W-1:0] tail_sel;

  assign record = {dqar_pkg::NAME_PTR, dqar_pkg::TYPE_A, dqar_pkg::CLASS_IN,
                   answer_ttl, dqar_pkg::RDLEN_IPV4, answer_address};
  assign tail_sel = TAIL_FINAL - tail_idx;

  // output register frees when empty or taken
  assign load = head_valid && (!out_valid || out_ready);

  // pick the next result
  always_comb begin
    pop           = 1'b0;
    tail_on_next  = tail_on;
    tail_idx_next = tail_idx;
    byte_next     = '0;
    last_next     = 1'b0;
    verdict_next  = dqar_pkg::VERDICT_BYTE;
    if (load) begin
      if (!head.fin) begin
        byte_next = head.data;
        pop       = 1'b1;
      end else if (!head.ok) begin
        last_next    = 1'b1;
        verdict_next = dqar_pkg::VERDICT_DISCARD;
        pop          = 1'b1;
      end else if (!tail_on && head.emit) begin
        // last question byte goes ahead of the record
        byte_next    = head.data;
        tail_on_next = 1'b1;
      end else begin
        byte_next = record[8*tail_sel +: 8];
        if (tail_idx == TAIL_FINAL) begin
          last_next     = 1'b1;
          verdict_next  = dqar_pkg::VERDICT_SEND;
          pop           = 1'b1;
          tail_on_next  = 1'b0;
          tail_idx_next = '0;
        end else begin
          tail_on_next  = 1'b1;
          tail_idx_next = tail_idx + 1'b1;
        end
      end
    end
  end

  // record position
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_on  <= 1'b0;
      tail_idx <= '0;
    end else begin
      tail_on  <= tail_on_next;
      tail_idx <= tail_idx_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      out_last <= last_next;
      verdict  <= verdict_next;
    end
  end

endmodule

// ===== rtl/dns_query_answer_rewriter.sv =====
// ----------------------------------------------------------------------------
// dns_query_answer_rewriter
// Streams a DNS query in and the rewritten reply with one A record out.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata in_byte, tlast in_last
//  m_       | out       | m_tvalid/m_tready  | tdata out_byte, tlast out_last,
//           |           |                    | tuser verdict
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One query byte per cycle is taken while s_tready is high. At datagram end the
//  16-byte answer record (17 results with the last question byte) leaves
//  the back stage at one byte per cycle while m_tready is high; the four-entry
//  queue fills and s_tready drops while it drains. Reset is synchronous and
//  clears the walk state, the queue and the registers to their defaults. Each
//  side stalls on its own through the queue and the output register.
//
module dns_query_answer_rewriter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] in_byte
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic                           m_tlast,
  output logic [1:0]                     m_tuser,   // [1:0] verdict
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dqar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic               in_fire;
  logic               push;
  logic               full;
  logic               pop;
  logic               head_valid;
  dqar_pkg::q_entry_t push_entry;
  dqar_pkg::q_entry_t head;
  logic [31:0]        answer_address;
  logic [31:0]        answer_ttl;

  assign s_tready  = !full;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= dqar_pkg::ADDRESS_RESET;
      answer_ttl     <= dqar_pkg::TTL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dqar_pkg::CFG_ANSWER_ADDRESS: answer_address <= cfg_data;
        dqar_pkg::CFG_ANSWER_TTL:     answer_ttl     <= cfg_data;
        default: ;
      endcase
    end
  end

  dqar_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  dqar_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dqar_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .answer_address (answer_address),
    .answer_ttl     (answer_ttl),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (m_tdata),
    .out_last       (m_tlast),
    .verdict        (m_tuser)
  );

endmodule

// ===== rtl/dqar_checker.sv =====
// ----------------------------------------------------------------------------
// dqar_assertions
// Port-level checks on the reply stream of the rewriter.
// ----------------------------------------------------------------------------
module dqar_assertions (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // a discard carries no byte and closes the datagram
  a_discard_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == dqar_pkg::VERDICT_DISCARD) |-> m_tlast && (m_tdata == 8'd0))
    else $error("discard result with data or without last");

  // only closing results carry a send or discard verdict
  a_mid_is_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tuser == dqar_pkg::VERDICT_BYTE))
    else $error("non-final result with closing verdict");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |->
      (m_tuser == dqar_pkg::VERDICT_SEND) || (m_tuser == dqar_pkg::VERDICT_DISCARD))
    else $error("final result marked as plain byte");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind dns_query_answer_rewriter dqar_assertions u_dqar_assertions (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== dv/dqar_checker.sv =====
// ----------------------------------------------------------------------------
// dqar_checker
// Watches the query, reply and register channels of the DNS query answer
// rewriter, works out every reply result from the accepted query bytes and
// compares each one with what the block sends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dqar_checker
  import dqar_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] in_byte
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [7:0]           m_tdata,   // [7:0] out_byte
  input  logic                 m_tlast,
  input  logic [1:0]           m_tuser,   // [1:0] verdict
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   checked,
  output int                   answers,
  output int                   discards
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] verdict;
  } reply_t;

  // replies still owed by the block, oldest first
  reply_t reply_q[$];
  reply_t want;

  // register copies
  logic [31:0] answer_address;
  logic [31:0] answer_ttl;

  // walk state of the current query
  logic [IDX_W-1:0]   byte_idx;
  logic [LABEL_W-1:0] label_at;
  logic [IDX_W-1:0]   q_end;
  phase_t             walk;
  logic               rejected;

  int mismatches;
  int n_checked;
  int n_answers;
  int n_discards;

  function automatic void restart_walk();
    byte_idx = '0;
    label_at = LABEL_W'(HDR_LEN);
    walk     = PH_NAME;
    q_end    = '0;
    rejected = 1'b0;
  endfunction

  function automatic void queue_reply(logic [7:0] data, logic last, logic [1:0] verdict);
    reply_t r;
    r.data    = data;
    r.last    = last;
    r.verdict = verdict;
    reply_q.push_back(r);
  endfunction

  // one query byte in, the reply results it causes queued
  function automatic void rewrite_byte(logic [7:0] b, logic last);
    logic [IDX_W-1:0] idx;
    logic             emit;
    logic [7:0]       ob;
    logic [127:0]     rec;
    idx  = byte_idx;
    emit = 1'b0;
    ob   = 8'h00;
    if (idx < MAX_PACKET) begin
      if (!rejected) begin
        if (idx < HDR_LEN) begin
          // header: id and question count kept, flags and counts rewritten
          emit = 1'b1;
          case (idx)
            OFF_FLAGS_HI: begin
              ob = FLAGS_HI;
              if (b[QR_BIT]) rejected = 1'b1;
            end
            OFF_FLAGS_LO: ob = FLAGS_LO;
            OFF_AN_LO:    ob = ANCOUNT_LO;
            OFF_ID_HI, OFF_ID_LO, OFF_QD_HI, OFF_QD_LO: ob = b;
            default:      ob = 8'h00;
          endcase
        end else if (walk == PH_NAME) begin
          // name: hop from length byte to length byte until the zero label
          emit = 1'b1;
          ob   = b;
          if (idx == label_at) begin
            if (b == 8'h00) begin
              q_end = IDX_W'(idx + QTAIL_LEN);
              if (q_end > MAX_PACKET - TAIL_LEN) rejected = 1'b1;
              else walk = PH_QTYPE;
            end else begin
              label_at = LABEL_W'(idx + b + 1);
            end
          end
        end else if (walk == PH_QTYPE) begin
          if (idx < q_end) begin
            emit = 1'b1;
            ob   = b;
          end
          if (idx + 1 >= q_end) walk = PH_DROP;
        end
      end
      byte_idx = IDX_W'(idx + 1);
    end

    if (!last) begin
      if (emit && !rejected) queue_reply(ob, 1'b0, VERDICT_BYTE);
    end else begin
      if (rejected || walk != PH_DROP) begin
        queue_reply(8'h00, 1'b1, VERDICT_DISCARD);
      end else begin
        if (emit) queue_reply(ob, 1'b0, VERDICT_BYTE);
        // answer record, most significant byte first
        rec = {NAME_PTR, TYPE_A, CLASS_IN, answer_ttl, RDLEN_IPV4, answer_address};
        for (int k = 0; k < TAIL_LEN - 1; k++) begin
          queue_reply(rec[127 - 8 * k -: 8], 1'b0, VERDICT_BYTE);
        end
        queue_reply(rec[7:0], 1'b1, VERDICT_SEND);
      end
      restart_walk();
    end
  endfunction

  // requests on all three channels, taken at the edge they complete on
  always @(posedge clk) begin
    if (rst) begin
      answer_address = ADDRESS_RESET;
      answer_ttl     = TTL_RESET;
      restart_walk();
      reply_q.delete();
      mismatches = 0;
      n_checked  = 0;
      n_answers  = 0;
      n_discards = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ANSWER_ADDRESS: answer_address = cfg_data;
          CFG_ANSWER_TTL:     answer_ttl     = cfg_data;
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) rewrite_byte(s_tdata, s_tlast);

      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%t: unexpected reply byte %02h last %0d verdict %0d, none pending",
                     $realtime, m_tdata, m_tlast, m_tuser);
          end
        end else begin
          want = reply_q.pop_front();
          n_checked++;
          if (want.verdict == VERDICT_SEND) n_answers++;
          if (want.verdict == VERDICT_DISCARD) n_discards++;
          if (m_tdata !== want.data || m_tlast !== want.last ||
              m_tuser !== want.verdict) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%t: reply mismatch, expected byte %02h last %0d verdict %0d,",
                       $realtime, want.data, want.last, want.verdict);
              $display("    got byte %02h last %0d verdict %0d",
                       m_tdata, m_tlast, m_tuser);
            end
          end
        end
      end
    end

    fail_count <= mismatches;
    pending    <= reply_q.size();
    checked    <= n_checked;
    answers    <= n_answers;
    discards   <= n_discards;
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the DNS query answer rewriter bench: builds query datagrams, good
// and broken, streams them in with random gaps, stalls the reply side and
// changes the answer registers between datagrams; the checker does the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dqar_pkg::*;

  localparam int RANDOM_BYTES = 480;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;
  logic                 m_tlast;
  logic [1:0]           m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int fail_count;
  int pending;
  int checked;
  int answers;
  int discards;

  // datagram being built
  logic [7:0] pkt[$];
  logic       calm;
  int         packets;
  int         query_bytes;
  int         reg_writes;

  dns_query_answer_rewriter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dqar_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .answers    (answers),
    .discards   (discards)
  );

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // header with random content, query bit forced
  function automatic void add_header(logic qr);
    logic [7:0] b;
    for (int i = 0; i < HDR_LEN; i++) begin
      b = 8'($urandom);
      if (i == OFF_FLAGS_HI) b[QR_BIT] = qr;
      pkt.push_back(b);
    end
  endfunction

  // labels filling exactly body bytes (0 or at least 2), then the zero label
  function automatic void add_name(int body, int maxlab);
    int rem;
    int len;
    rem = body;
    while (rem > 0) begin
      if (rem - 1 <= maxlab) len = rem - 1;
      else len = $urandom_range(1, (maxlab < rem - 3) ? maxlab : rem - 3);
      pkt.push_back(8'(len));
      repeat (len) pkt.push_back(8'($urandom));
      rem -= len + 1;
    end
    pkt.push_back(8'h00);
  endfunction

  function automatic void add_bytes(int n);
    repeat (n) pkt.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // stream the built datagram, one request per byte
  task automatic send_packet();
    int gap;
    calm = ($urandom_range(0, 3) == 0);
    foreach (pkt[i]) begin
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= pkt[i];
      s_tlast  <= (i == pkt.size() - 1);
      do @(posedge clk); while (!s_tready);
      if (i < MAX_PACKET) query_bytes++;
    end
    pkt.delete();
    packets++;
  endtask

  // let every owed reply leave, then give the back stage time to finish
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // reply side back-pressure
  initial begin : receiver
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    int kind;
    int body;
    int start;
    calm        = 1'b0;
    packets     = 0;
    query_bytes = 0;
    reg_writes  = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ANSWER_ADDRESS;
    cfg_data  <= 32'h0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // smallest answerable query: root name, question ends on the last byte
    add_header(1'b0);
    add_name(0, 2);
    add_bytes(4);
    send_packet();
    // labelled name with trailing bytes that are dropped
    add_header(1'b0);
    add_name(8, 4);
    add_bytes(7);
    send_packet();
    // header of all ones apart from the query bit
    pkt = {8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
           8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    add_name(6, 6);
    add_bytes(4);
    send_packet();
    // header of all zeros
    repeat (HDR_LEN) pkt.push_back(8'h00);
    add_name(3, 2);
    add_bytes(4);
    send_packet();
    // response received, rest of the query ignored
    add_header(1'b1);
    add_name(5, 4);
    add_bytes(4);
    send_packet();
    // short datagrams
    add_bytes(11);
    send_packet();
    add_bytes(1);
    send_packet();
    // header only, ends in the name walk
    add_header(1'b0);
    send_packet();
    // name overruns the datagram
    add_header(1'b0);
    pkt.push_back(8'h05);
    add_bytes(2);
    send_packet();
    // type and class one byte short
    add_header(1'b0);
    add_name(4, 3);
    add_bytes(3);
    send_packet();
    // question ending right on the limit, then one byte past it
    add_header(1'b0);
    add_name(479, 255);
    add_bytes(4);
    send_packet();
    add_header(1'b0);
    add_name(480, 255);
    add_bytes(4);
    send_packet();
    // oversize datagram, bytes past the limit ignored
    add_header(1'b0);
    add_name(10, 5);
    add_bytes(530 - pkt.size());
    send_packet();

    // register extremes
    write_reg(CFG_ANSWER_ADDRESS, 32'h0000_0000);
    write_reg(CFG_ANSWER_TTL, 32'hFFFF_FFFF);
    add_header(1'b0);
    add_name(6, 3);
    add_bytes(4);
    send_packet();
    write_reg(CFG_ANSWER_ADDRESS, 32'hFFFF_FFFF);
    write_reg(CFG_ANSWER_TTL, 32'h0000_0000);
    add_header(1'b0);
    add_name(6, 3);
    add_bytes(4);
    send_packet();

    // random datagrams, mostly well formed, back to back
    start = query_bytes;
    while (query_bytes - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1)) write_reg(CFG_ANSWER_ADDRESS, any_word());
        else write_reg(CFG_ANSWER_TTL, any_word());
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_header(1'b0);
        body = $urandom_range(0, 30);
        if (body == 1) body = 2;
        add_name(body, ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(2, 12));
        add_bytes(4 + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0));
      end else if (kind < 76) begin
        add_header(1'b1);
        add_name(2 * $urandom_range(0, 6), 8);
        add_bytes($urandom_range(0, 6));
      end else if (kind < 82) begin
        add_bytes($urandom_range(1, 11));
      end else if (kind < 88) begin
        add_header(1'b0);
        body = $urandom_range(1, 255);
        pkt.push_back(8'(body));
        add_bytes($urandom_range(0, (body - 1 < 10) ? body - 1 : 10));
      end else if (kind < 94) begin
        add_header(1'b0);
        add_name(2 * $urandom_range(0, 5), 6);
        add_bytes($urandom_range(0, 3));
      end else begin
        add_bytes($urandom_range(1, 40));
      end
      send_packet();
    end

    settle();
    $display("covered %0d datagrams, %0d query bytes and %0d register writes",
             packets, query_bytes, reg_writes);
    $display("checked %0d reply results: %0d answered, %0d discarded",
             checked, answers, discards);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d replies outstanding", pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dqar_pkg.sv
rtl/dqar_front.sv
rtl/dqar_queue.sv
rtl/dqar_back.sv
rtl/dns_query_answer_rewriter.sv
rtl/dqar_checker.sv
dv/dqar_checker.sv
dv/tb.sv
